// ----- rtl/core/winder_manual_jog_controller_top_defines.svh -----
// assertion macros used by the jog controller checker
`ifndef WINDER_MANUAL_JOG_CONTROLLER_TOP_DEFINES_SVH
`define WINDER_MANUAL_JOG_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define WMJC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define WMJC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/wmjc_pkg.sv -----
// types, constants and codes of the manual jog controller
`timescale 1ns / 1ps

package wmjc_pkg;

    // storage width defaults
    localparam int TURN_BITS_DEFAULT     = 24;
    localparam int POSITION_BITS_DEFAULT = 32;
    localparam int BUTTON_COUNT          = 5;

    // configuration port geometry and reset values
    localparam int CFG_INDEX_W             = 2;
    localparam int CFG_DATA_W              = 20;
    localparam logic [7:0]  DEBOUNCE_RESET = 8'd20;
    localparam logic [19:0] STEPS_RESET    = 20'd3200;
    localparam logic [15:0] RATIO_RESET    = 16'd0;

    // button lanes
    localparam int BTN_CW    = 0;
    localparam int BTN_CCW   = 1;
    localparam int BTN_LEFT  = 2;
    localparam int BTN_RIGHT = 3;
    localparam int BTN_WIND  = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_STEPS    = 2'd1,
        CFG_RATIO    = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [7:0]  debounce_ms;
        logic [19:0] steps_per_rev;
        logic [15:0] carriage_ratio;
    } cfg_t;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        cw_raw;
        logic        ccw_raw;
        logic        left_raw;
        logic        right_raw;
        logic        wind_raw;
        logic        hold_switch;
        logic        auto_running;
        logic        dir_forward;
    } tick_t;

    typedef struct packed {
        logic               spindle_pulse;
        logic               spindle_dir;
        logic               spindle_en;
        logic               carriage_pulse;
        logic               carriage_dir;
        logic               carriage_en;
        logic               carriage_manual_active;
        logic               carriage_move_dir;
        logic [23:0]        turn_count;
        logic signed [31:0] carriage_position;
        logic               any_pressed;
    } result_t;

    // control handed from the pipeline to the motion logic
    typedef struct packed {
        logic enable;
        logic auto_running;
        logic hold_switch;
        logic dir_forward;
    } motion_ctrl_t;

    // driver lines kept between ticks
    typedef struct packed {
        logic mdir;
        logic mact;
        logic cen;
        logic cdir;
        logic sen;
        logic sdir;
    } drive_lines_t;

endpackage

// ----- rtl/core/wmjc_stream_if.sv -----
// valid/ready channel carrying one payload per transaction
`timescale 1ns / 1ps

interface wmjc_stream_if #(
    parameter type data_t = logic
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/wmjc_debounce.sv -----
// five-lane button debouncer with per-lane change timestamps
`timescale 1ns / 1ps

module wmjc_debounce (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic [31:0]                       now_ms,
    input  logic [wmjc_pkg::BUTTON_COUNT-1:0] raw,
    input  logic [7:0]                        debounce_ms,
    output logic [wmjc_pkg::BUTTON_COUNT-1:0] stable_next
);

    logic [wmjc_pkg::BUTTON_COUNT-1:0] stable_reg;
    logic [wmjc_pkg::BUTTON_COUNT-1:0] last_reg;
    logic [wmjc_pkg::BUTTON_COUNT-1:0] last_next;
    logic [31:0] change_time_reg  [wmjc_pkg::BUTTON_COUNT];
    logic [31:0] change_time_next [wmjc_pkg::BUTTON_COUNT];
    logic [31:0] elapsed          [wmjc_pkg::BUTTON_COUNT];

    // per lane: restart the timer on an edge, accept the level once it settled
    always_comb
    begin
        for (int i = 0; i < wmjc_pkg::BUTTON_COUNT; i++)
        begin
            last_next[i]        = raw[i];
            change_time_next[i] = (raw[i] != last_reg[i]) ? now_ms : change_time_reg[i];
            elapsed[i]          = now_ms - change_time_next[i];
            stable_next[i]      = (elapsed[i] >= {24'd0, debounce_ms}) ? raw[i] : stable_reg[i];
        end
    end

    // lane state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg <= '0;
            last_reg   <= '0;
            for (int i = 0; i < wmjc_pkg::BUTTON_COUNT; i++)
            begin
                change_time_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            stable_reg <= stable_next;
            last_reg   <= last_next;
            for (int i = 0; i < wmjc_pkg::BUTTON_COUNT; i++)
            begin
                change_time_reg[i] <= change_time_next[i];
            end
        end
    end

endmodule

// ----- rtl/core/wmjc_motion.sv -----
// service winding, spindle and carriage jog logic with its counters
`timescale 1ns / 1ps

module wmjc_motion #(
    parameter int TURN_BITS     = wmjc_pkg::TURN_BITS_DEFAULT,
    parameter int POSITION_BITS = wmjc_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  wmjc_pkg::motion_ctrl_t            ctrl,
    input  wmjc_pkg::cfg_t                    cfg,
    input  logic [wmjc_pkg::BUTTON_COUNT-1:0] stable,
    output wmjc_pkg::result_t                 res
);

    logic                     spindle_jog_reg, spindle_jog_next;
    logic                     carriage_jog_reg, carriage_jog_next;
    logic                     wind_reg, wind_next;
    logic [19:0]              step_cnt_reg, step_cnt_next;
    logic [15:0]              acc_reg, acc_next;
    logic [TURN_BITS-1:0]     turn_reg, turn_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    wmjc_pkg::drive_lines_t   lines_reg, lines_next;

    logic        s_step;
    logic        c_step;
    logic        cw, ccw, left, right;
    logic [16:0] acc_sum;
    logic [19:0] cnt_base;
    logic [19:0] cnt_inc;

    assign cw    = stable[wmjc_pkg::BTN_CW];
    assign ccw   = stable[wmjc_pkg::BTN_CCW];
    assign left  = stable[wmjc_pkg::BTN_LEFT];
    assign right = stable[wmjc_pkg::BTN_RIGHT];

    assign acc_sum = {1'b0, acc_reg} + {1'b0, cfg.carriage_ratio};

    // one tick of the jog controller
    always_comb
    begin
        spindle_jog_next  = spindle_jog_reg;
        carriage_jog_next = carriage_jog_reg;
        wind_next         = wind_reg;
        step_cnt_next     = step_cnt_reg;
        acc_next          = acc_reg;
        turn_next         = turn_reg;
        pos_next          = pos_reg;
        lines_next        = lines_reg;
        s_step            = 1'b0;
        c_step            = 1'b0;
        cnt_base          = spindle_jog_reg ? step_cnt_reg : 20'd0;
        cnt_inc           = cnt_base + 20'd1;

        if (ctrl.auto_running)
        begin
            lines_next.mact = 1'b0;
        end
        else if (stable[wmjc_pkg::BTN_WIND])
        begin
            // service winding: spindle always steps, carriage follows the ratio
            if (!wind_reg)
            begin
                lines_next.sdir = 1'b1;
                lines_next.sen  = 1'b1;
                lines_next.cdir = ctrl.dir_forward;
                lines_next.cen  = 1'b1;
                lines_next.mact = 1'b1;
                lines_next.mdir = ctrl.dir_forward;
                wind_next       = 1'b1;
            end
            s_step   = 1'b1;
            acc_next = acc_sum[15:0];
            if (acc_sum[16])
            begin
                c_step          = 1'b1;
                lines_next.mdir = ctrl.dir_forward;
                pos_next        = ctrl.dir_forward ? pos_reg + POSITION_BITS'(1)
                                                   : pos_reg - POSITION_BITS'(1);
            end
        end
        else
        begin
            // service release
            if (wind_reg)
            begin
                lines_next.cen  = 1'b0;
                lines_next.mact = 1'b0;
                wind_next       = 1'b0;
            end

            // spindle jog with turn counting
            if (cw != ccw)
            begin
                if (!spindle_jog_reg)
                begin
                    lines_next.sdir  = cw;
                    lines_next.sen   = 1'b1;
                    spindle_jog_next = 1'b1;
                end
                s_step = 1'b1;
                if (cnt_inc >= cfg.steps_per_rev)
                begin
                    step_cnt_next = '0;
                    if (cw)
                    begin
                        if (turn_reg != {TURN_BITS{1'b1}})
                        begin
                            turn_next = turn_reg + TURN_BITS'(1);
                        end
                    end
                    else if (turn_reg != '0)
                    begin
                        turn_next = turn_reg - TURN_BITS'(1);
                    end
                end
                else
                begin
                    step_cnt_next = cnt_inc;
                end
            end
            else
            begin
                spindle_jog_next = 1'b0;
                step_cnt_next    = '0;
                lines_next.sen   = ctrl.hold_switch;
            end

            // carriage jog, one microstep per tick
            if (left != right)
            begin
                if (!carriage_jog_reg)
                begin
                    lines_next.cdir   = right;
                    lines_next.cen    = 1'b1;
                    carriage_jog_next = 1'b1;
                end
                c_step          = 1'b1;
                pos_next        = right ? pos_reg + POSITION_BITS'(1)
                                        : pos_reg - POSITION_BITS'(1);
                lines_next.mdir = right;
                lines_next.mact = 1'b1;
            end
            else
            begin
                if (carriage_jog_reg)
                begin
                    lines_next.cen    = 1'b0;
                    carriage_jog_next = 1'b0;
                end
                lines_next.mact = 1'b0;
            end
        end
    end

    // result of this tick
    always_comb
    begin
        res.spindle_pulse          = s_step;
        res.spindle_dir            = lines_next.sdir;
        res.spindle_en             = lines_next.sen;
        res.carriage_pulse         = c_step;
        res.carriage_dir           = lines_next.cdir;
        res.carriage_en            = lines_next.cen;
        res.carriage_manual_active = lines_next.mact;
        res.carriage_move_dir      = lines_next.mdir;
        res.turn_count             = 24'(turn_next);
        res.carriage_position      = $signed(32'(pos_next));
        res.any_pressed            = !ctrl.auto_running && (stable != '0);
    end

    // controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spindle_jog_reg  <= 1'b0;
            carriage_jog_reg <= 1'b0;
            wind_reg         <= 1'b0;
            step_cnt_reg     <= '0;
            acc_reg          <= '0;
            turn_reg         <= '0;
            pos_reg          <= '0;
            lines_reg        <= '0;
        end
        else if (ctrl.enable)
        begin
            spindle_jog_reg  <= spindle_jog_next;
            carriage_jog_reg <= carriage_jog_next;
            wind_reg         <= wind_next;
            step_cnt_reg     <= step_cnt_next;
            acc_reg          <= acc_next;
            turn_reg         <= turn_next;
            pos_reg          <= pos_next;
            lines_reg        <= lines_next;
        end
    end

endmodule

// ----- rtl/core/winder_manual_jog_controller_top.sv -----
// top level of the manual jog controller: tick register, config, result register
`timescale 1ns / 1ps

// Manual jog controller for a coil winder. Every tick transaction is taken into an
// input register; when it advances, the debouncers and the jog, turn and position
// logic update their state in one pass and the result lands in an output register,
// so a result is offered once its tick has passed the input register and the output
// register and, while the result side takes results, a new tick is taken every cycle
// (one tick per clock). A stalled result holds the tick register, so the input stalls
// once that register is full. The one-pass state update of debounce timers, turn
// counter, ratio accumulator and position sets that figure. Configuration writes take
// effect at the next edge and are meant for times when no tick is in flight.
module winder_manual_jog_controller_top #(
    parameter int TURN_BITS     = wmjc_pkg::TURN_BITS_DEFAULT,
    parameter int POSITION_BITS = wmjc_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    wmjc_stream_if.sink                      tick,
    wmjc_stream_if.source                    result,
    input  logic                             cfg_we,
    input  logic [wmjc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wmjc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic                 tick_valid_reg, tick_valid_next;
    wmjc_pkg::tick_t      tick_data_reg;
    logic                 result_valid_reg, result_valid_next;
    wmjc_pkg::result_t    result_data_reg;
    wmjc_pkg::result_t    result_comb;
    wmjc_pkg::cfg_t       cfg_reg, cfg_next;
    wmjc_pkg::motion_ctrl_t motion_ctrl;
    logic                 advance;
    logic                 tick_ready;
    logic [wmjc_pkg::BUTTON_COUNT-1:0] raw;
    logic [wmjc_pkg::BUTTON_COUNT-1:0] stable;

    // pipeline handshake
    assign advance      = tick_valid_reg && (!result_valid_reg || result.ready);
    assign tick_ready   = !tick_valid_reg || advance;
    assign tick.ready   = tick_ready;
    assign result.valid = result_valid_reg;
    assign result.data  = result_data_reg;

    always_comb
    begin
        tick_valid_next   = tick_ready ? tick.valid : tick_valid_reg;
        result_valid_next = advance ? 1'b1 : (result.ready ? 1'b0 : result_valid_reg);
    end

    // configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (wmjc_pkg::cfg_index_t'(cfg_index))
                wmjc_pkg::CFG_DEBOUNCE: cfg_next.debounce_ms    = cfg_data[7:0];
                wmjc_pkg::CFG_STEPS:    cfg_next.steps_per_rev  = cfg_data[19:0];
                wmjc_pkg::CFG_RATIO:    cfg_next.carriage_ratio = cfg_data[15:0];
                default:                cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms    <= wmjc_pkg::DEBOUNCE_RESET;
            cfg_reg.steps_per_rev  <= wmjc_pkg::STEPS_RESET;
            cfg_reg.carriage_ratio <= wmjc_pkg::RATIO_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            tick_valid_reg   <= tick_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (tick_ready && tick.valid)
        begin
            tick_data_reg <= tick.data;
        end
        if (advance)
        begin
            result_data_reg <= result_comb;
        end
    end

    // button lanes in debouncer order
    always_comb
    begin
        raw                      = '0;
        raw[wmjc_pkg::BTN_CW]    = tick_data_reg.cw_raw;
        raw[wmjc_pkg::BTN_CCW]   = tick_data_reg.ccw_raw;
        raw[wmjc_pkg::BTN_LEFT]  = tick_data_reg.left_raw;
        raw[wmjc_pkg::BTN_RIGHT] = tick_data_reg.right_raw;
        raw[wmjc_pkg::BTN_WIND]  = tick_data_reg.wind_raw;
    end

    wmjc_debounce u_debounce (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance && !tick_data_reg.auto_running),
        .now_ms      (tick_data_reg.now_ms),
        .raw         (raw),
        .debounce_ms (cfg_reg.debounce_ms),
        .stable_next (stable)
    );

    always_comb
    begin
        motion_ctrl.enable       = advance;
        motion_ctrl.auto_running = tick_data_reg.auto_running;
        motion_ctrl.hold_switch  = tick_data_reg.hold_switch;
        motion_ctrl.dir_forward  = tick_data_reg.dir_forward;
    end

    wmjc_motion #(
        .TURN_BITS     (TURN_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_motion (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (motion_ctrl),
        .cfg    (cfg_reg),
        .stable (stable),
        .res    (result_comb)
    );

endmodule

// ----- rtl/core/wmjc_checker.sv -----
// port-level checks of the manual jog controller and their binding
`timescale 1ns / 1ps
`include "winder_manual_jog_controller_top_defines.svh"

module wmjc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input wmjc_pkg::result_t out_data
);

    // a stalled result stays put
    `WMJC_ASSERT_NEXT(a_result_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

    // with the result side free, a tick is always taken
    `WMJC_ASSERT_IMPLY(a_ready_free, clk, rst_n, !out_valid, in_ready, "tick refused with output free")

    // a spindle step always goes out with the driver enabled
    `WMJC_ASSERT_IMPLY(a_spindle_enabled, clk, rst_n, out_valid && out_data.spindle_pulse, out_data.spindle_en, "spindle step without enable")

    // no step while nothing is pressed
    `WMJC_ASSERT_IMPLY(a_idle_no_step, clk, rst_n, out_valid && !out_data.any_pressed, !out_data.spindle_pulse && !out_data.carriage_pulse, "step with no button pressed")

endmodule

bind winder_manual_jog_controller_top wmjc_checker u_wmjc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (tick.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
);

// ----- tb/tb.sv -----
// self-checking testbench of the manual jog controller top level
`timescale 1ns / 1ps

module tb;
    import wmjc_pkg::*;

    // run limits and pacing
    localparam int CYCLE_LIMIT     = 200000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int HOLD_OFF_CYCLES = 80;

    // button masks, one bit per lane
    localparam logic [BUTTON_COUNT-1:0] PRESS_NONE  = '0;
    localparam logic [BUTTON_COUNT-1:0] PRESS_ALL   = '1;
    localparam logic [BUTTON_COUNT-1:0] PRESS_CW    = BUTTON_COUNT'(1) << BTN_CW;
    localparam logic [BUTTON_COUNT-1:0] PRESS_CCW   = BUTTON_COUNT'(1) << BTN_CCW;
    localparam logic [BUTTON_COUNT-1:0] PRESS_LEFT  = BUTTON_COUNT'(1) << BTN_LEFT;
    localparam logic [BUTTON_COUNT-1:0] PRESS_RIGHT = BUTTON_COUNT'(1) << BTN_RIGHT;
    localparam logic [BUTTON_COUNT-1:0] PRESS_WIND  = BUTTON_COUNT'(1) << BTN_WIND;

    // hand-written outputs for the opening ticks
    localparam logic    TYPED         = 1'b1;
    localparam logic    PREDICTED     = 1'b0;
    localparam result_t ALL_LOW       = '0;
    localparam result_t CW_JOG_RESULT = {8'b1110_0000, 24'd0, 32'd0, 1'b1};

    typedef struct packed {
        logic [31:0]             now_ms;
        logic [BUTTON_COUNT-1:0] buttons;
        logic                    hold;
        logic                    autorun;
        logic                    fwd;
        logic                    typed;
        result_t                 want;
    } jog_row_t;

    // directed ticks: time, buttons, {hold, auto, forward}, source of the output
    jog_row_t directed_rows [25] = '{
        {32'd0,         PRESS_NONE,              3'b000, TYPED,     ALL_LOW},
        {32'd5,         PRESS_CW,                3'b000, TYPED,     ALL_LOW},
        {32'd25,        PRESS_CW,                3'b000, TYPED,     CW_JOG_RESULT},
        {32'd30,        PRESS_CCW,               3'b000, PREDICTED, ALL_LOW},
        {32'd50,        PRESS_CCW,               3'b000, PREDICTED, ALL_LOW},
        {32'd50,        PRESS_CCW,               3'b010, PREDICTED, ALL_LOW},
        {32'd60,        PRESS_NONE,              3'b100, PREDICTED, ALL_LOW},
        {32'd80,        PRESS_NONE,              3'b100, PREDICTED, ALL_LOW},
        {32'd80,        PRESS_RIGHT,             3'b001, PREDICTED, ALL_LOW},
        {32'd100,       PRESS_RIGHT,             3'b001, PREDICTED, ALL_LOW},
        {32'd101,       PRESS_RIGHT | PRESS_LEFT, 3'b001, PREDICTED, ALL_LOW},
        {32'd121,       PRESS_RIGHT | PRESS_LEFT, 3'b001, PREDICTED, ALL_LOW},
        {32'd121,       PRESS_LEFT,              3'b000, PREDICTED, ALL_LOW},
        {32'd141,       PRESS_LEFT,              3'b000, PREDICTED, ALL_LOW},
        {32'd141,       PRESS_WIND | PRESS_LEFT, 3'b001, PREDICTED, ALL_LOW},
        {32'd161,       PRESS_WIND | PRESS_LEFT, 3'b000, PREDICTED, ALL_LOW},
        {32'd162,       PRESS_WIND | PRESS_LEFT, 3'b001, PREDICTED, ALL_LOW},
        {32'd162,       PRESS_WIND,              3'b011, PREDICTED, ALL_LOW},
        {32'd200,       PRESS_NONE,              3'b000, PREDICTED, ALL_LOW},
        {32'd220,       PRESS_NONE,              3'b000, PREDICTED, ALL_LOW},
        {32'hFFFF_FFF0, PRESS_CW,                3'b000, PREDICTED, ALL_LOW},
        {32'h0000_0004, PRESS_CW,                3'b000, PREDICTED, ALL_LOW},
        {32'hFFFF_FFFF, PRESS_ALL,               3'b101, PREDICTED, ALL_LOW},
        {32'h0000_0013, PRESS_ALL,               3'b101, PREDICTED, ALL_LOW},
        {32'h0000_0014, PRESS_NONE,              3'b000, PREDICTED, ALL_LOW}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    wmjc_stream_if #(.data_t(tick_t))   tick_ch ();
    wmjc_stream_if #(.data_t(result_t)) result_ch ();

    winder_manual_jog_controller_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // controller shadow: settings, debouncers, jog flags, counters and drive lines
    cfg_t                    jog_settings   = '{DEBOUNCE_RESET, STEPS_RESET, RATIO_RESET};
    logic [BUTTON_COUNT-1:0] btn_stable     = '0;
    logic [BUTTON_COUNT-1:0] btn_last       = '0;
    logic [31:0]             btn_changed_at [BUTTON_COUNT] = '{default: '0};
    logic                    spin_jogging   = 1'b0;
    logic                    carr_jogging   = 1'b0;
    logic                    winding        = 1'b0;
    logic [19:0]             step_in_turn   = '0;
    logic [15:0]             ratio_acc      = '0;
    logic [23:0]             turns          = '0;
    logic [31:0]             position       = '0;
    drive_lines_t            line_state     = '0;

    result_t     jog_outputs_due [$];
    int          mismatch_count   = 0;
    int          results_seen     = 0;
    int          cycle_count      = 0;
    logic [31:0] clock_ms         = '0;
    logic        src_idling       = 1'b1;
    logic        sink_idling      = 1'b1;
    logic        hold_off_pending = 1'b0;

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // one update tick of the controller: advances the shadow, returns its outputs
    function automatic result_t jog_tick_update(input tick_t t);
        result_t                 r;
        logic [BUTTON_COUNT-1:0] raw;
        logic [31:0]             held_ms;
        logic [16:0]             acc_sum;
        logic                    cw;
        logic                    ccw;
        logic                    go_left;
        logic                    go_right;
        int                      b;
        r = '0;
        raw[BTN_CW]    = t.cw_raw;
        raw[BTN_CCW]   = t.ccw_raw;
        raw[BTN_LEFT]  = t.left_raw;
        raw[BTN_RIGHT] = t.right_raw;
        raw[BTN_WIND]  = t.wind_raw;

        if (t.auto_running)
        begin
            // buttons not sampled, only the service flag drops
            line_state.mact = 1'b0;
        end
        else
        begin
            // debounce, elapsed time taken modulo 2^32
            for (b = 0; b < BUTTON_COUNT; b++)
            begin
                if (raw[b] != btn_last[b])
                begin
                    btn_last[b]       = raw[b];
                    btn_changed_at[b] = t.now_ms;
                end
                held_ms = t.now_ms - btn_changed_at[b];
                if (held_ms >= 32'(jog_settings.debounce_ms))
                    btn_stable[b] = raw[b];
            end
            r.any_pressed = |btn_stable;
            cw       = btn_stable[BTN_CW];
            ccw      = btn_stable[BTN_CCW];
            go_left  = btn_stable[BTN_LEFT];
            go_right = btn_stable[BTN_RIGHT];

            if (btn_stable[BTN_WIND])
            begin
                // service winding overrides the jog buttons
                if (!winding)
                begin
                    line_state.sdir = 1'b1;
                    line_state.sen  = 1'b1;
                    line_state.cdir = t.dir_forward;
                    line_state.cen  = 1'b1;
                    line_state.mact = 1'b1;
                    line_state.mdir = t.dir_forward;
                    winding         = 1'b1;
                end
                r.spindle_pulse = 1'b1;
                acc_sum = {1'b0, ratio_acc} + {1'b0, jog_settings.carriage_ratio};
                if (acc_sum[16])
                begin
                    r.carriage_pulse = 1'b1;
                    position         = t.dir_forward ? position + 32'd1 : position - 32'd1;
                    line_state.mdir  = t.dir_forward;
                end
                ratio_acc = acc_sum[15:0];
            end
            else
            begin
                // service release, then jog in the same tick
                if (winding)
                begin
                    line_state.cen  = 1'b0;
                    line_state.mact = 1'b0;
                    winding         = 1'b0;
                end

                // spindle jog with turn counting
                if (cw != ccw)
                begin
                    if (!spin_jogging)
                    begin
                        line_state.sdir = cw;
                        line_state.sen  = 1'b1;
                        spin_jogging    = 1'b1;
                        step_in_turn    = '0;
                    end
                    r.spindle_pulse = 1'b1;
                    step_in_turn    = step_in_turn + 20'd1;
                    if (step_in_turn >= jog_settings.steps_per_rev)
                    begin
                        step_in_turn = '0;
                        if (cw && turns != '1)
                            turns = turns + 24'd1;
                        else if (!cw && turns != '0)
                            turns = turns - 24'd1;
                    end
                end
                else
                begin
                    spin_jogging   = 1'b0;
                    step_in_turn   = '0;
                    line_state.sen = t.hold_switch;
                end

                // carriage jog, one microstep per tick
                if (go_left != go_right)
                begin
                    if (!carr_jogging)
                    begin
                        line_state.cdir = go_right;
                        line_state.cen  = 1'b1;
                        carr_jogging    = 1'b1;
                    end
                    r.carriage_pulse = 1'b1;
                    position         = go_right ? position + 32'd1 : position - 32'd1;
                    line_state.mdir  = go_right;
                    line_state.mact  = 1'b1;
                end
                else
                begin
                    if (carr_jogging)
                    begin
                        line_state.cen = 1'b0;
                        carr_jogging   = 1'b0;
                    end
                    line_state.mact = 1'b0;
                end
            end
        end

        r.spindle_dir            = line_state.sdir;
        r.spindle_en             = line_state.sen;
        r.carriage_dir           = line_state.cdir;
        r.carriage_en            = line_state.cen;
        r.carriage_manual_active = line_state.mact;
        r.carriage_move_dir      = line_state.mdir;
        r.turn_count             = turns;
        r.carriage_position      = position;
        return r;
    endfunction

    function automatic tick_t to_tick(input logic [31:0] now_ms,
                                      input logic [BUTTON_COUNT-1:0] buttons,
                                      input logic hold, input logic autorun,
                                      input logic fwd);
        tick_t t;
        t.now_ms       = now_ms;
        t.cw_raw       = buttons[BTN_CW];
        t.ccw_raw      = buttons[BTN_CCW];
        t.left_raw     = buttons[BTN_LEFT];
        t.right_raw    = buttons[BTN_RIGHT];
        t.wind_raw     = buttons[BTN_WIND];
        t.hold_switch  = hold;
        t.auto_running = autorun;
        t.dir_forward  = fwd;
        return t;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("%0t mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s is %0h, want %0h",
                                      results_seen, name, got, want));
    endtask

    // offer one tick transaction, with random idle cycles ahead of it
    task automatic send_tick(input tick_t t, input logic typed, input result_t typed_want);
        result_t modeled;
        while (src_idling && $urandom_range(99) < 31)
        begin
            tick_ch.valid <= 1'b0;
            @(posedge clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.data  <= t;
        @(posedge clk);
        while (!tick_ch.ready)
            @(posedge clk);
        modeled = jog_tick_update(t);
        jog_outputs_due.push_back(typed ? typed_want : modeled);
    endtask

    // stop offering and wait until every outstanding result is back
    task automatic settle_block();
        tick_ch.valid <= 1'b0;
        while (jog_outputs_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // idle the block, then write all three registers back to back
    task automatic retune(input logic [7:0] deb, input logic [19:0] steps,
                          input logic [15:0] ratio);
        settle_block();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DEBOUNCE;
        cfg_data  <= CFG_DATA_W'(deb);
        @(posedge clk);
        cfg_index <= CFG_STEPS;
        cfg_data  <= steps;
        @(posedge clk);
        cfg_index <= CFG_RATIO;
        cfg_data  <= CFG_DATA_W'(ratio);
        @(posedge clk);
        cfg_we <= 1'b0;
        jog_settings.debounce_ms    = deb;
        jog_settings.steps_per_rev  = steps;
        jog_settings.carriage_ratio = ratio;
    endtask

    // held button gestures with bounce, direction flips and time jumps
    task automatic run_gestures(input int ticks);
        int                      sent;
        int                      span;
        int                      k;
        int                      dt_max;
        logic [BUTTON_COUNT-1:0] pattern;
        logic [BUTTON_COUNT-1:0] raw;
        logic                    hold;
        logic                    autorun;
        logic                    fwd;
        sent   = 0;
        dt_max = int'(jog_settings.debounce_ms) / 8 + 2;
        while (sent < ticks)
        begin
            case ($urandom_range(0, 11))
                0:       pattern = PRESS_NONE;
                1:       pattern = PRESS_CW;
                2:       pattern = PRESS_CCW;
                3:       pattern = PRESS_LEFT;
                4:       pattern = PRESS_RIGHT;
                5:       pattern = PRESS_WIND;
                6:       pattern = PRESS_CW | PRESS_CCW;
                7:       pattern = PRESS_LEFT | PRESS_RIGHT;
                8:       pattern = PRESS_CW | PRESS_RIGHT;
                9:       pattern = PRESS_CCW | PRESS_LEFT;
                10:      pattern = PRESS_WIND | PRESS_CW | PRESS_LEFT;
                default: pattern = BUTTON_COUNT'($urandom());
            endcase
            span    = $urandom_range(1, 40);
            hold    = 1'($urandom());
            autorun = ($urandom_range(99) < 8);
            fwd     = 1'($urandom());
            for (k = 0; k < span && sent < ticks; k++)
            begin
                raw = pattern;
                if ($urandom_range(99) < 8)
                    raw = raw ^ (BUTTON_COUNT'(1) << $urandom_range(0, BUTTON_COUNT - 1));
                if ($urandom_range(99) < 3)
                    fwd = ~fwd;
                if ($urandom_range(99) < 3)
                    hold = ~hold;
                if ($urandom_range(999) < 15)
                    clock_ms = $urandom();
                else
                    clock_ms = clock_ms + $urandom_range(0, dt_max);
                send_tick(to_tick(clock_ms, raw, hold, autorun, fwd), PREDICTED, ALL_LOW);
                sent++;
            end
        end
    endtask

    // result side ready, random stalls plus one long hold-off on request
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_pending)
            begin
                hold_off_pending = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                result_ch.ready <= !(sink_idling && $urandom_range(99) < 31);
            end
        end
    end

    // compare each result transaction with the oldest outstanding tick
    always @(posedge clk)
    begin : result_checker
        result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (jog_outputs_due.size() == 0)
            begin
                report_mismatch($sformatf("result %0d with no tick outstanding", results_seen));
            end
            else
            begin
                want = jog_outputs_due.pop_front();
                check_field("spindle_pulse", 32'(result_ch.data.spindle_pulse),
                            32'(want.spindle_pulse));
                check_field("spindle_dir", 32'(result_ch.data.spindle_dir),
                            32'(want.spindle_dir));
                check_field("spindle_en", 32'(result_ch.data.spindle_en),
                            32'(want.spindle_en));
                check_field("carriage_pulse", 32'(result_ch.data.carriage_pulse),
                            32'(want.carriage_pulse));
                check_field("carriage_dir", 32'(result_ch.data.carriage_dir),
                            32'(want.carriage_dir));
                check_field("carriage_en", 32'(result_ch.data.carriage_en),
                            32'(want.carriage_en));
                check_field("carriage_manual_active",
                            32'(result_ch.data.carriage_manual_active),
                            32'(want.carriage_manual_active));
                check_field("carriage_move_dir", 32'(result_ch.data.carriage_move_dir),
                            32'(want.carriage_move_dir));
                check_field("turn_count", 32'(result_ch.data.turn_count),
                            32'(want.turn_count));
                check_field("carriage_position", 32'(result_ch.data.carriage_position),
                            32'(want.carriage_position));
                check_field("any_pressed", 32'(result_ch.data.any_pressed),
                            32'(want.any_pressed));
            end
            results_seen++;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** winder_manual_jog_controller_top: FAILED **");
            $finish;
        end
    end

    // reset, directed ticks, then randomized phases over several settings
    initial
    begin
        rst_n         <= 1'b0;
        tick_ch.valid <= 1'b0;
        tick_ch.data  <= '0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_DEBOUNCE;
        cfg_data      <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed ticks under the reset settings
        foreach (directed_rows[i])
            send_tick(to_tick(directed_rows[i].now_ms, directed_rows[i].buttons,
                              directed_rows[i].hold, directed_rows[i].autorun,
                              directed_rows[i].fwd),
                      directed_rows[i].typed, directed_rows[i].want);

        // no debounce, a turn per step, carry nearly every tick
        retune(8'd0, 20'd1, 16'hFFFF);
        run_gestures(150);

        // longest debounce and turn, no carriage feed, time wraps mid-phase
        clock_ms = 32'hFFFF_FE00;
        retune(8'd255, 20'hFFFFF, 16'd0);
        run_gestures(150);

        // receiver holds off long enough to back up the input
        retune(8'd20, 20'd4, 16'd16384);
        hold_off_pending = 1'b1;
        run_gestures(150);

        // no idling on either side
        retune(8'd3, 20'd2, 16'hFFFF);
        src_idling  = 1'b0;
        sink_idling = 1'b0;
        run_gestures(150);
        src_idling  = 1'b1;
        sink_idling = 1'b1;

        retune(8'($urandom_range(0, 40)), 20'($urandom_range(1, 10)), 16'($urandom()));
        run_gestures(150);

        // smallest nonzero feed
        retune(8'd8, 20'd5, 16'd1);
        run_gestures(150);

        retune(8'($urandom_range(0, 255)), 20'($urandom_range(1, 16)), 16'($urandom()));
        run_gestures(150);

        settle_block();
        if (mismatch_count == 0)
            $display("** winder_manual_jog_controller_top: PASSED **");
        else
            $display("** winder_manual_jog_controller_top: FAILED **");
        $finish;
    end

endmodule

// ----- winder_manual_jog_controller_top.f -----
+incdir+rtl/core
rtl/core/wmjc_pkg.sv
rtl/core/wmjc_stream_if.sv
rtl/core/wmjc_debounce.sv
rtl/core/wmjc_motion.sv
rtl/core/winder_manual_jog_controller_top.sv
rtl/core/wmjc_checker.sv
tb/tb.sv
